FILE: hw/rtl/irpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpp_pkg
// Shared types, codes and constants of the iRprop+ weight update unit.
// ----------------------------------------------------------------------------

package irpp_pkg;

  // Data widths (Q16.16 words and 31-bit step registers)
  localparam int unsigned DW = 32;
  localparam int unsigned RW = 31;

  // Item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // Stored gradient sign codes; the unused code reads as zero
  localparam logic [1:0] SGN_ZERO = 2'b00;
  localparam logic [1:0] SGN_POS  = 2'b01;
  localparam logic [1:0] SGN_NEG  = 2'b11;

  // floor(x / 5) == (x * RECIP5) >> RECIP5_SHIFT for every 32-bit x
  localparam logic [DW-1:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int unsigned   RECIP5_SHIFT = 34;
  localparam int unsigned   QW           = 2 * DW - RECIP5_SHIFT;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_STEP  = 2'd0,
    CFG_MIN_STEP  = 2'd1,
    CFG_INIT_STEP = 2'd2
  } cfg_idx_e;

  // Update class of one item
  typedef enum logic [1:0] {
    CLS_LOAD,
    CLS_AGREE,
    CLS_FLIP,
    CLS_KEEP
  } cls_e;

  // One table entry
  typedef struct packed {
    logic [DW-1:0] weight;
    logic [DW-1:0] step;
    logic [1:0]    sign;
  } tbl_entry_t;

  // Table write request
  typedef struct packed {
    logic       we;
    tbl_entry_t data;
  } tbl_wr_t;

  // Clamp a 33-bit two's complement value to the 32-bit range
  function automatic logic [DW-1:0] sat33(input logic [DW:0] v);
    logic [DW-1:0] r;
    if (v[DW] != v[DW-1]) begin
      r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/irpp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpp_table
// Per-weight state memory: weight, signed step and last gradient sign.
// One write port, one registered read port.
// ----------------------------------------------------------------------------

module irpp_table #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                                  clk_i,
  input  irpp_pkg::tbl_wr_t                     wr_i,
  input  logic [$clog2(ENTRIES)-1:0]            wr_idx_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0]            rd_idx_i,
  output irpp_pkg::tbl_entry_t                  rd_data_o
);

  irpp_pkg::tbl_entry_t mem_q [ENTRIES];
  irpp_pkg::tbl_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_idx_i] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: hw/rtl/irpp_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpp_pipe
// Update datapath: classify, grow by 1.2, select update and step, add to
// the weight with saturation, write back and hold the result.
// ----------------------------------------------------------------------------

module irpp_pipe #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // item entering stage 1, read data arrives with it
  input  logic                                  in_take_i,
  input  logic                                  in_func_i,
  input  logic [$clog2(ENTRIES)-1:0]            in_idx_i,
  input  logic [irpp_pkg::DW-1:0]               in_value_i,
  input  logic                                  in_rose_i,
  input  irpp_pkg::tbl_entry_t                  rd_data_i,
  input  logic [irpp_pkg::RW-1:0]               max_step_i,
  input  logic [irpp_pkg::RW-1:0]               min_step_i,
  input  logic [irpp_pkg::RW-1:0]               init_step_i,
  output logic                                  s1_free_o,
  output logic [3:0]                            busy_v_o,
  output logic [3:0][$clog2(ENTRIES)-1:0]       busy_idx_o,
  output irpp_pkg::tbl_wr_t                     wr_o,
  output logic [$clog2(ENTRIES)-1:0]            wr_idx_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [irpp_pkg::DW-1:0]               new_weight_o,
  output logic [irpp_pkg::DW-1:0]               applied_update_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned DW = irpp_pkg::DW;
  localparam int unsigned QW = irpp_pkg::QW;

  // Stage occupancy and flow
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_free, s2_free, s3_free, s4_free, out_free;

  assign out_free = !out_v_q || !out_stall_i;
  assign s4_free  = !s4_v_q || out_free;
  assign s3_free  = !s3_v_q || s4_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_free  = !s1_v_q || s2_free;

  // Stage 1: item plus table read
  logic          s1_func_q;
  logic [AW-1:0] s1_idx_q;
  logic [DW-1:0] s1_val_q;
  logic          s1_rose_q;

  // Stage 2: class and step magnitude
  irpp_pkg::cls_e s2_cls_d, s2_cls_q;
  logic [DW-1:0]  s2_mag_d, s2_mag_q;
  logic [AW-1:0]  s2_idx_q;
  logic [DW-1:0]  s2_val_q, s2_wt_q, s2_step_q;
  logic           s2_rose_q;

  // Stage 3: quotient mag / 5
  logic [2*DW-1:0] s3_prod_d;
  logic [QW-1:0]   s3_quot_q;
  irpp_pkg::cls_e  s3_cls_q;
  logic [DW-1:0]   s3_mag_q, s3_val_q, s3_wt_q, s3_step_q;
  logic [AW-1:0]   s3_idx_q;
  logic            s3_rose_q;

  // Stage 4: update, new step and sign
  logic [DW-1:0] s4_wt_d, s4_upd_d, s4_step_d;
  logic [1:0]    s4_sign_d;
  logic [DW-1:0] s4_wt_q, s4_upd_q, s4_step_q;
  logic [1:0]    s4_sign_q;
  logic [AW-1:0] s4_idx_q;

  // Output register
  logic [DW-1:0] out_wt_d;
  logic [DW-1:0] out_wt_q, out_upd_q;

  // ---- valid bits ---------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_take_i;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_free) begin
        s3_v_q <= s2_v_q;
      end
      if (s4_free) begin
        s4_v_q <= s3_v_q;
      end
      if (out_free) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  // ---- stage 1 -> 2: classify ---------------------------------------------
  logic ps_pos, ps_neg, g_pos, g_neg;

  always_comb begin
    ps_pos = (rd_data_i.sign == irpp_pkg::SGN_POS);
    ps_neg = (rd_data_i.sign == irpp_pkg::SGN_NEG);
    g_neg  = s1_val_q[DW-1];
    g_pos  = !s1_val_q[DW-1] && (s1_val_q != '0);
    if (s1_func_q == irpp_pkg::FUNC_LOAD) begin
      s2_cls_d = irpp_pkg::CLS_LOAD;
    end else if ((ps_pos && g_pos) || (ps_neg && g_neg)) begin
      s2_cls_d = irpp_pkg::CLS_AGREE;
    end else if ((ps_pos && g_neg) || (ps_neg && g_pos)) begin
      s2_cls_d = irpp_pkg::CLS_FLIP;
    end else begin
      s2_cls_d = irpp_pkg::CLS_KEEP;
    end
    s2_mag_d = rd_data_i.step[DW-1] ? (DW'(0) - rd_data_i.step) : rd_data_i.step;
  end

  // ---- stage 2 -> 3: reciprocal multiply ----------------------------------
  assign s3_prod_d = s2_mag_q * irpp_pkg::RECIP5;

  // ---- stage 3 -> 4: select update, step and sign -------------------------
  logic [DW:0]   grow, neg_step;
  logic [DW-1:0] cap, half, min_x;

  always_comb begin
    grow     = {1'b0, s3_mag_q} + (DW+1)'(s3_quot_q);
    cap      = (grow > (DW+1)'(max_step_i)) ? DW'(max_step_i) : grow[DW-1:0];
    neg_step = (DW+1)'(0) - {s3_step_q[DW-1], s3_step_q};
    half     = s3_mag_q >> 1;
    min_x    = DW'(min_step_i);
    s4_wt_d   = s3_wt_q;
    s4_upd_d  = '0;
    s4_step_d = '0;
    s4_sign_d = irpp_pkg::SGN_ZERO;
    case (s3_cls_q)
      irpp_pkg::CLS_LOAD: begin
        s4_wt_d   = s3_val_q;
        s4_step_d = DW'(init_step_i);
        s4_sign_d = irpp_pkg::SGN_POS;
      end
      irpp_pkg::CLS_AGREE: begin
        s4_upd_d  = s3_val_q[DW-1] ? (DW'(0) - cap) : cap;
        s4_step_d = s4_upd_d;
        s4_sign_d = s3_val_q[DW-1] ? irpp_pkg::SGN_NEG : irpp_pkg::SGN_POS;
      end
      irpp_pkg::CLS_FLIP: begin
        // revert the last step only when the error rose
        s4_upd_d  = s3_rose_q ? irpp_pkg::sat33(neg_step) : '0;
        s4_step_d = (half < min_x) ? min_x : half;
        s4_sign_d = irpp_pkg::SGN_ZERO;
      end
      irpp_pkg::CLS_KEEP: begin
        s4_upd_d  = s3_val_q[DW-1] ? (DW'(0) - s3_mag_q)
                                   : irpp_pkg::sat33({1'b0, s3_mag_q});
        s4_step_d = s4_upd_d;
        if (s3_val_q == '0) begin
          s4_sign_d = irpp_pkg::SGN_ZERO;
        end else if (s3_val_q[DW-1]) begin
          s4_sign_d = irpp_pkg::SGN_NEG;
        end else begin
          s4_sign_d = irpp_pkg::SGN_POS;
        end
      end
      default: begin
        s4_upd_d = '0;
      end
    endcase
  end

  // ---- stage 4 -> out: weight sum and write back --------------------------
  assign out_wt_d = irpp_pkg::sat33({s4_wt_q[DW-1], s4_wt_q} + {s4_upd_q[DW-1], s4_upd_q});

  always_comb begin
    wr_o.we          = s4_v_q && out_free;
    wr_o.data.weight = out_wt_d;
    wr_o.data.step   = s4_step_q;
    wr_o.data.sign   = s4_sign_q;
  end
  assign wr_idx_o = s4_idx_q;

  // ---- payload registers --------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      s1_func_q <= in_func_i;
      s1_idx_q  <= in_idx_i;
      s1_val_q  <= in_value_i;
      s1_rose_q <= in_rose_i;
    end
    if (s2_free && s1_v_q) begin
      s2_cls_q  <= s2_cls_d;
      s2_mag_q  <= s2_mag_d;
      s2_idx_q  <= s1_idx_q;
      s2_val_q  <= s1_val_q;
      s2_wt_q   <= rd_data_i.weight;
      s2_step_q <= rd_data_i.step;
      s2_rose_q <= s1_rose_q;
    end
    if (s3_free && s2_v_q) begin
      s3_quot_q <= s3_prod_d[2*DW-1:irpp_pkg::RECIP5_SHIFT];
      s3_cls_q  <= s2_cls_q;
      s3_mag_q  <= s2_mag_q;
      s3_idx_q  <= s2_idx_q;
      s3_val_q  <= s2_val_q;
      s3_wt_q   <= s2_wt_q;
      s3_step_q <= s2_step_q;
      s3_rose_q <= s2_rose_q;
    end
    if (s4_free && s3_v_q) begin
      s4_wt_q   <= s4_wt_d;
      s4_upd_q  <= s4_upd_d;
      s4_step_q <= s4_step_d;
      s4_sign_q <= s4_sign_d;
      s4_idx_q  <= s3_idx_q;
    end
    if (out_free && s4_v_q) begin
      out_wt_q  <= out_wt_d;
      out_upd_q <= s4_upd_q;
    end
  end

  assign s1_free_o        = s1_free;
  assign busy_v_o         = {s4_v_q, s3_v_q, s2_v_q, s1_v_q};
  assign busy_idx_o       = {s4_idx_q, s3_idx_q, s2_idx_q, s1_idx_q};
  assign out_valid_o      = out_v_q;
  assign new_weight_o     = out_wt_q;
  assign applied_update_o = out_upd_q;

  // ---- assertions ---------------------------------------------------------
  a_s1_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> !((s2_v_q && s2_idx_q == s1_idx_q) || (s3_v_q && s3_idx_q == s1_idx_q) ||
                 (s4_v_q && s4_idx_q == s1_idx_q)))
    else $error("two in-flight items share a table entry (stage 1)");

  a_s2_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> !((s3_v_q && s3_idx_q == s2_idx_q) || (s4_v_q && s4_idx_q == s2_idx_q)))
    else $error("two in-flight items share a table entry (stage 2)");

  a_s3_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && s4_v_q) |-> (s3_idx_q != s4_idx_q))
    else $error("two in-flight items share a table entry (stage 3)");

  a_wb_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |=> (out_v_q && out_wt_q == $past(out_wt_d)))
    else $error("write back without a matching result");

endmodule

FILE: hw/rtl/irprop_plus_weight_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprop_plus_weight_update_unit
// iRprop+ weight update engine over a table of Q16.16 weights, steps and
// last gradient signs; one load or update item in, one result item out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o | func_i entry_i value_i error_rose_i
//  out     | output    | out_valid_o/out_stall_i | new_weight_o applied_update_o
//  cfg     | input     | cfg_we_i                | cfg_idx_i cfg_wdata_i
//
//  An accepted item passes through stages 1-4 and the output register to its
//  result; the pipeline takes one item per cycle unless a stall or a hazard holds it.
//  An item whose entry matches one still in stages 1-4 is held at the input
//  until that item writes back: the table is read at accept and written
//  only as an item leaves stage 4.
//  Reset clears the valid bits and loads the step registers with their
//  defaults; table contents are undefined until a load item writes them.
//  A stalled result holds in the output register while earlier stages keep
//  filling bubbles; the input stalls once stage 1 cannot advance or on a hazard.
// ----------------------------------------------------------------------------

module irprop_plus_weight_update_unit #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [irpp_pkg::RW-1:0]       cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [9:0]                    entry_i,
  input  logic signed [31:0]            value_i,
  input  logic                          error_rose_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            new_weight_o,
  output logic signed [31:0]            applied_update_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned IW = (AW > 10) ? AW : 10;
  localparam bit          POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  // Fold the entry field onto the table: a plain cut for a power-of-two
  // depth, otherwise a short subtract ladder on a 10-bit value.
  function automatic logic [AW-1:0] idx_of(input logic [9:0] e);
    logic [IW-1:0] r;
    r = IW'(e);
    if (!POW2) begin
      for (int k = 9; k >= 0; k--) begin
        if (32'(r) >= (32'(ENTRIES) << k)) begin
          r = r - IW'(32'(ENTRIES) << k);
        end
      end
    end
    return AW'(r);
  endfunction

  // Step registers
  logic [irpp_pkg::RW-1:0] max_step_q, min_step_q, init_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= 31'd3276800;
      min_step_q  <= 31'd1;
      init_step_q <= 31'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        irpp_pkg::CFG_MAX_STEP:  max_step_q  <= cfg_wdata_i;
        irpp_pkg::CFG_MIN_STEP:  min_step_q  <= cfg_wdata_i;
        irpp_pkg::CFG_INIT_STEP: init_step_q <= cfg_wdata_i;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // Input side: hold an item whose entry is still in flight
  logic [AW-1:0]         in_idx;
  logic                  hazard;
  logic                  s1_free;
  logic                  take;
  logic [3:0]            busy_v;
  logic [3:0][AW-1:0]    busy_idx;

  assign in_idx = idx_of(entry_i);

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (busy_v[k] && (busy_idx[k] == in_idx)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !s1_free || hazard;
  assign take       = in_valid_i && !in_stall_o;

  // Table and datapath
  irpp_pkg::tbl_wr_t    wr;
  logic [AW-1:0]        wr_idx;
  irpp_pkg::tbl_entry_t rd_data;
  logic [irpp_pkg::DW-1:0] new_weight, applied_update;

  irpp_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_idx_i  (wr_idx),
    .rd_en_i   (take),
    .rd_idx_i  (in_idx),
    .rd_data_o (rd_data)
  );

  irpp_pipe #(
    .ENTRIES (ENTRIES)
  ) u_pipe (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_take_i        (take),
    .in_func_i        (func_i),
    .in_idx_i         (in_idx),
    .in_value_i       ($unsigned(value_i)),
    .in_rose_i        (error_rose_i),
    .rd_data_i        (rd_data),
    .max_step_i       (max_step_q),
    .min_step_i       (min_step_q),
    .init_step_i      (init_step_q),
    .s1_free_o        (s1_free),
    .busy_v_o         (busy_v),
    .busy_idx_o       (busy_idx),
    .wr_o             (wr),
    .wr_idx_o         (wr_idx),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .new_weight_o     (new_weight),
    .applied_update_o (applied_update)
  );

  assign new_weight_o     = $signed(new_weight);
  assign applied_update_o = $signed(applied_update);

endmodule
